// ----- rtl/scsa_pkg.sv -----
// Shared types, codes and helper functions of the size-class slab allocator.
package scsa_pkg;

  localparam int unsigned NUM_CLASSES = 8;
  localparam int unsigned SLOTS_MAX   = 128;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_BIG      = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTOWNED = 3'd4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [12:0] PAGE_BYTES = 13'd4096;

  typedef struct packed {
    logic        cmd;
    logic [12:0] req_size;
    logic [19:0] free_addr;
  } in_t;

  typedef struct packed {
    logic [19:0] alloc_addr;
    logic [2:0]  status;
  } out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD,
    OP_SCAN,
    OP_MTF1,
    OP_MTF2,
    OP_MTF3,
    OP_NEW1,
    OP_NEW2,
    OP_FCLR,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] st;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_sz;
    logic too_big;
    logic not_owned;
    logic cur_nil;
    logic found;
    logic last;
    logic is_head;
    logic full;
  } dp_sts_t;

  // Smallest class c whose slot size 32 << c holds the request.
  function automatic logic [2:0] size_class(input logic [12:0] size);
    logic [2:0] c;
    c = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if (size <= (13'd32 << i)) c = 3'(i);
    end
    return c;
  endfunction

  // Bitmap mask with one bit set for every slot that a page of class c has.
  function automatic logic [SLOTS_MAX-1:0] slot_mask(input logic [2:0] c);
    logic [7:0] sh;
    sh = 8'd128 - (8'd128 >> c);
    return {SLOTS_MAX{1'b1}} >> sh;
  endfunction

endpackage

// ----- rtl/scsa_ctrl.sv -----
// Controller state machine of the slab allocator.
module scsa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output scsa_pkg::dp_cmd_t dp_cmd,
  input  scsa_pkg::dp_sts_t dp_sts
);
  import scsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ACHK, S_SCAN, S_M1, S_M2, S_M3, S_N1, S_N2,
    S_FRD, S_FCLR, S_FIN, S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] st_r, st_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt  = state_r;
    st_nxt     = st_r;
    dp_cmd.op  = OP_NONE;
    dp_cmd.st  = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.op = OP_LOAD;
          st_nxt    = ST_OK;
          if (in_cmd == CMD_FREE) begin
            if (dp_sts.not_owned) begin
              st_nxt    = ST_NOTOWNED;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_FRD;
            end
          end else if (dp_sts.zero_sz) begin
            st_nxt    = ST_ZERO;
            state_nxt = S_FIN;
          end else if (dp_sts.too_big) begin
            st_nxt    = ST_BIG;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_ACHK;
          end
        end
      end
      S_ACHK: begin
        dp_cmd.op = OP_RD;
        if (dp_sts.cur_nil) begin
          if (dp_sts.full) begin
            st_nxt    = ST_FULL;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_N1;
          end
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        dp_cmd.op = OP_SCAN;
        if (dp_sts.found) begin
          state_nxt = dp_sts.is_head ? S_FIN : S_M1;
        end else if (dp_sts.last) begin
          if (dp_sts.full) begin
            st_nxt    = ST_FULL;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_N1;
          end
        end else begin
          state_nxt = S_ACHK;
        end
      end
      S_M1: begin
        dp_cmd.op = OP_MTF1;
        state_nxt = S_M2;
      end
      S_M2: begin
        dp_cmd.op = OP_MTF2;
        state_nxt = S_M3;
      end
      S_M3: begin
        dp_cmd.op = OP_MTF3;
        state_nxt = S_FIN;
      end
      S_N1: begin
        dp_cmd.op = OP_NEW1;
        state_nxt = S_N2;
      end
      S_N2: begin
        dp_cmd.op = OP_NEW2;
        state_nxt = S_FIN;
      end
      S_FRD: begin
        dp_cmd.op = OP_RD;
        state_nxt = S_FCLR;
      end
      S_FCLR: begin
        dp_cmd.op = OP_FCLR;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        dp_cmd.op = OP_FIN;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

// ----- rtl/scsa_dp.sv -----
// Datapath of the slab allocator: page memories, class heads and result register.
module scsa_dp #(
  parameter int unsigned NUM_PAGES = 256,
  parameter int unsigned PW = 9,
  parameter int unsigned AW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  scsa_pkg::in_t     in_data,
  input  scsa_pkg::dp_cmd_t dp_cmd,
  output scsa_pkg::dp_sts_t dp_sts,
  output scsa_pkg::out_t    out_data
);
  import scsa_pkg::*;

  localparam logic [PW-1:0] NIL = PW'(NUM_PAGES);

  logic [SLOTS_MAX-1:0] sm_mem  [NUM_PAGES];
  logic [PW-1:0]        nx_mem  [NUM_PAGES];
  logic [PW-1:0]        pv_mem  [NUM_PAGES];
  logic [2:0]           own_mem [NUM_PAGES];

  logic [PW-1:0] head_r [NUM_CLASSES];
  logic [PW-1:0] used_r, cur_r, guard_r;
  logic [2:0]    cls_r;
  logic [11:0]   off_r;
  logic [19:0]   res_addr_r;
  out_t          out_r;

  logic [SLOTS_MAX-1:0] sm_q;
  logic [PW-1:0]        nx_q, pv_q;
  logic [2:0]           own_q;

  logic [2:0]           in_cls;
  logic [12:0]          in_page13, used13, cur13;
  logic [PW-1:0]        h;
  logic [SLOTS_MAX-1:0] avail, slot_oh, fr_oh;
  logic [6:0]           slot, fr_slot;

  logic                 sm_we, nx_we, pv_we, own_we;
  logic [PW-1:0]        sm_wa, nx_wa, pv_wa, own_wa;
  logic [SLOTS_MAX-1:0] sm_wd;
  logic [PW-1:0]        nx_wd, pv_wd;

  assign in_cls    = size_class(in_data.req_size);
  assign in_page13 = 13'(in_data.free_addr[19:12]);
  assign used13    = 13'(used_r);
  assign cur13     = 13'(cur_r);
  assign h         = head_r[cls_r];
  assign avail     = ~sm_q & slot_mask(cls_r);

  always_comb begin
    slot = 7'd0;
    for (int i = SLOTS_MAX - 1; i >= 0; i--) begin
      if (avail[i]) slot = 7'(i);
    end
  end

  assign slot_oh = SLOTS_MAX'(1) << slot;
  assign fr_slot = 7'(off_r[11:5] >> own_q);
  assign fr_oh   = SLOTS_MAX'(1) << fr_slot;

  assign dp_sts.zero_sz   = (in_data.req_size == 13'd0);
  assign dp_sts.too_big   = (in_data.req_size > PAGE_BYTES);
  assign dp_sts.not_owned = (in_page13 >= used13);
  assign dp_sts.cur_nil   = (cur_r == NIL);
  assign dp_sts.found     = |avail;
  assign dp_sts.last      = (nx_q == NIL) || (PW'(guard_r + 1'b1) == NIL);
  assign dp_sts.is_head   = (cur_r == h);
  assign dp_sts.full      = (used_r == NIL);

  assign out_data = out_r;

  always_comb begin
    sm_we  = 1'b0; sm_wa  = cur_r;  sm_wd = sm_q | slot_oh;
    nx_we  = 1'b0; nx_wa  = cur_r;  nx_wd = h;
    pv_we  = 1'b0; pv_wa  = cur_r;  pv_wd = NIL;
    own_we = 1'b0; own_wa = used_r;
    case (dp_cmd.op)
      OP_SCAN: sm_we = dp_sts.found;
      OP_MTF1: begin
        nx_we = 1'b1; nx_wa = pv_q; nx_wd = nx_q;
        pv_we = (nx_q != NIL); pv_wa = nx_q; pv_wd = pv_q;
      end
      OP_MTF2: begin
        nx_we = 1'b1;
        pv_we = 1'b1;
      end
      OP_MTF3: begin
        pv_we = 1'b1; pv_wa = h; pv_wd = cur_r;
      end
      OP_NEW1: begin
        own_we = 1'b1;
        sm_we  = 1'b1; sm_wa = used_r; sm_wd = SLOTS_MAX'(1);
        nx_we  = 1'b1; nx_wa = used_r;
        pv_we  = 1'b1; pv_wa = used_r;
      end
      OP_NEW2: begin
        pv_we = (h != NIL); pv_wa = h; pv_wd = cur_r;
      end
      OP_FCLR: begin
        sm_we = 1'b1; sm_wd = sm_q & ~fr_oh;
      end
      default: ;
    endcase
  end

  // Page memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (sm_we)  sm_mem[sm_wa[AW-1:0]]   <= sm_wd;
    if (nx_we)  nx_mem[nx_wa[AW-1:0]]   <= nx_wd;
    if (pv_we)  pv_mem[pv_wa[AW-1:0]]   <= pv_wd;
    if (own_we) own_mem[own_wa[AW-1:0]] <= cls_r;
    if (dp_cmd.op == OP_RD) begin
      sm_q  <= sm_mem[cur_r[AW-1:0]];
      nx_q  <= nx_mem[cur_r[AW-1:0]];
      pv_q  <= pv_mem[cur_r[AW-1:0]];
      own_q <= own_mem[cur_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) head_r[i] <= NIL;
    end else begin
      case (dp_cmd.op)
        OP_MTF3: head_r[cls_r] <= cur_r;
        OP_NEW1: used_r        <= PW'(used_r + 1'b1);
        OP_NEW2: head_r[cls_r] <= cur_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (dp_cmd.op)
      OP_LOAD: begin
        cls_r      <= in_cls;
        off_r      <= in_data.free_addr[11:0];
        cur_r      <= (in_data.cmd == CMD_FREE) ? PW'(in_page13) : head_r[in_cls];
        guard_r    <= '0;
        res_addr_r <= '0;
      end
      OP_SCAN: begin
        if (dp_sts.found) begin
          res_addr_r <= {cur13[7:0], 12'(12'(slot) << (4'd5 + 4'(cls_r)))};
        end else begin
          cur_r   <= nx_q;
          guard_r <= PW'(guard_r + 1'b1);
        end
      end
      OP_NEW1: begin
        cur_r      <= used_r;
        res_addr_r <= {used13[7:0], 12'd0};
      end
      OP_FIN: begin
        out_r.alloc_addr <= res_addr_r;
        out_r.status     <= dp_cmd.st;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/size_class_slab_allocator_core.sv -----
// Top level of the size-class slab allocator: controller plus datapath.
//
// The block takes one transaction at a time on the input channel (in_valid,
// in_ready, in_data) and returns exactly one result transaction on the output
// channel (out_valid, out_ready, out_data) for each of them.
// An allocate maps req_size to one of eight classes (32 to 4096 bytes), walks
// that class's page list from its head, and takes the lowest free slot of the
// first page that has one; that page then moves to the head of the list. When
// no listed page has room, the next unused page joins the class. A free
// clears the slot that holds free_addr in an owned page.
// An allocate visits each page of its list walk with one memory read and one
// bitmap search, then moves the found page to the front (three steps, none
// when it is already the head) or links in a new page (two steps); a free
// reads and clears its page, and a rejected request goes straight to the
// result register. The list walk sets the rate.
// A new input transaction is taken only after the previous result has been
// accepted; while the receiver stalls, out_data holds and in_ready stays low.
// Synchronous reset marks all pages unowned and all class lists empty at
// once; the page memories need no clearing pass because the count of pages
// handed out tells which entries are valid.
module size_class_slab_allocator_core #(
  parameter int unsigned NUM_PAGES = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  scsa_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output scsa_pkg::out_t out_data
);
  import scsa_pkg::*;

  // Page index width holds the null index NUM_PAGES; memory address width
  // covers only the real pages.
  localparam int unsigned PW = $clog2(NUM_PAGES + 1);
  localparam int unsigned AW = $clog2(NUM_PAGES);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  scsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_data.cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts)
  );

  scsa_dp #(
    .NUM_PAGES (NUM_PAGES),
    .PW        (PW),
    .AW        (AW)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .dp_cmd   (dp_cmd),
    .dp_sts   (dp_sts),
    .out_data (out_data)
  );

endmodule

// ----- rtl/scsa_checker.sv -----
// Port-level assertion checker of the slab allocator and its bind.
module scsa_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input scsa_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input scsa_pkg::out_t out_data
);
  import scsa_pkg::*;

  // A result waiting to be taken stays and holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // One transaction at a time: no new input while a result waits.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result waits");

  // Results with any status other than OK carry a zero address.
  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.alloc_addr == 20'd0)
    else $error("nonzero address with error status");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_NOTOWNED)
    else $error("undefined status code");

  // An accepted input is not answered straight after the edge that accepts it.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result appeared in the cycle after acceptance");

endmodule

bind size_class_slab_allocator_core scsa_checker u_scsa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- dv/tb.sv -----
// Self-checking testbench for the size-class slab allocator core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scsa_pkg::*;

  localparam int unsigned NPAGES = 256;
  localparam int unsigned NIL = NPAGES;
  localparam int unsigned STALL_LIMIT = 20000;

  // Allocator model: tracks page ownership, slot bitmaps and the per-class
  // page lists, and holds the queue of results still owed by the block.
  class slab_scoreboard;
    logic [3:0]   owner [NPAGES];
    logic [127:0] slots [NPAGES];
    int unsigned  nxt [NPAGES];
    int unsigned  prv [NPAGES];
    int unsigned  head [NUM_CLASSES];
    int unsigned  used;
    out_t         owed [$];
    int unsigned  mismatches;
    // Addresses granted and not yet freed; used to steer frees.
    logic [19:0]  live [$];

    function void clear();
      for (int i = 0; i < NPAGES; i++) begin
        owner[i] = 4'hf;
        slots[i] = '0;
        nxt[i] = NIL;
        prv[i] = NIL;
      end
      for (int c = 0; c < NUM_CLASSES; c++) head[c] = NIL;
      used = 0;
      mismatches = 0;
    endfunction

    function void to_front(int unsigned c, int unsigned p);
      int unsigned h;
      h = head[c];
      if (p == h) return;
      if (prv[p] < NIL) nxt[prv[p]] = nxt[p];
      if (nxt[p] < NIL) prv[nxt[p]] = prv[p];
      prv[p] = NIL;
      nxt[p] = h;
      if (h < NIL) prv[h] = p;
      head[c] = p;
    endfunction

    // Works out the result of one accepted input transaction.
    function void note_input(in_t t);
      out_t r;
      int unsigned c, n, p, guard, pg, off;
      bit done;
      r.alloc_addr = '0;
      r.status = ST_OK;
      if (t.cmd == CMD_ALLOC) begin
        if (t.req_size == 0) r.status = ST_ZERO;
        else if (t.req_size > 4096) r.status = ST_BIG;
        else begin
          c = 0;
          while (c < 7 && t.req_size > (32 << c)) c++;
          n = 128 >> c;
          p = head[c];
          guard = 0;
          done = 0;
          while (p < NIL && guard < NPAGES && !done) begin
            for (int s = 0; s < n; s++) begin
              if (!slots[p][s]) begin
                slots[p][s] = 1'b1;
                to_front(c, p);
                r.alloc_addr = 20'(p * 4096 + s * (32 << c));
                done = 1;
                break;
              end
            end
            if (!done) p = nxt[p];
            guard++;
          end
          if (!done) begin
            if (used >= NPAGES) r.status = ST_FULL;
            else begin
              p = used;
              used++;
              owner[p] = 4'(c);
              slots[p] = 128'd1;
              prv[p] = NIL;
              nxt[p] = head[c];
              if (head[c] < NIL) prv[head[c]] = p;
              head[c] = p;
              r.alloc_addr = 20'(p * 4096);
            end
          end
          if (r.status == ST_OK) live.push_back(r.alloc_addr);
        end
      end else begin
        pg = t.free_addr >> 12;
        off = t.free_addr & 12'hfff;
        if (pg >= NPAGES || owner[pg] >= NUM_CLASSES) r.status = ST_NOTOWNED;
        else slots[pg][off >> (5 + owner[pg])] = 1'b0;
      end
      owed.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result addr=%h status=%0d",
                   got.alloc_addr, got.status);
        return;
      end
      exp_r = owed.pop_front();
      if (got.alloc_addr !== exp_r.alloc_addr || got.status !== exp_r.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected addr=%h status=%0d, got addr=%h status=%0d",
                   exp_r.alloc_addr, exp_r.status, got.alloc_addr, got.status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  slab_scoreboard sb;
  bit quiet_phase = 0;
  int unsigned idle_cycles = 0;

  size_class_slab_allocator_core #(.NUM_PAGES(NPAGES)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every transaction is observed at the rising edge where it completes.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // Watchdog: too long without any transaction means the block has hung.
  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: ready toggles in random bursts, except in the last phase.
  initial begin
    int unsigned k;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        k = $urandom_range(1, 14);
        repeat (k - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        k = $urandom_range(1, 20);
        repeat (k - 1) @(negedge clk);
      end
    end
  end

  // Drives one transaction and holds it until the block accepts it. Valid
  // is dropped only when an idle gap comes before the next transaction, so
  // valid and data change once per falling edge.
  task automatic send_item(input in_t t);
    int unsigned gap;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_alloc(input logic [12:0] sz);
    in_t t;
    t.cmd = CMD_ALLOC;
    t.req_size = sz;
    t.free_addr = 20'($urandom);
    send_item(t);
  endtask

  task automatic send_free(input logic [19:0] a);
    in_t t;
    t.cmd = CMD_FREE;
    t.req_size = 13'($urandom);
    t.free_addr = a;
    send_item(t);
  endtask

  // Sizes favor the small classes so that the pool lasts most of the run.
  function automatic logic [12:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 13'd0;
    if (r < 6) return 13'($urandom_range(4097, 8191));
    if (r < 70) return 13'($urandom_range(1, 256));
    if (r < 90) return 13'($urandom_range(257, 1024));
    return 13'($urandom_range(1025, 4096));
  endfunction

  initial begin
    int unsigned idx;
    logic [19:0] a;
    sb = new();
    sb.clear();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero size, oversize, each class boundary and a free of an
    // unowned page before any page is handed out.
    send_free(20'hfffff);
    send_alloc(13'd0);
    send_alloc(13'd4097);
    send_alloc(13'h1fff);
    send_alloc(13'd1);
    send_alloc(13'd32);
    send_alloc(13'd33);
    send_alloc(13'd64);
    send_alloc(13'd128);
    send_alloc(13'd256);
    send_alloc(13'd512);
    send_alloc(13'd1024);
    send_alloc(13'd2048);
    send_alloc(13'd4096);
    send_alloc(13'd4096);
    // Inner address of a granted slot, then a double free of it.
    send_free(20'h00011);
    send_free(20'h00000);
    send_free(20'h00000);
    send_alloc(13'd20);
    // Owned range boundary: page just past the handed-out ones.
    send_free(20'(sb.used * 4096));
    send_free(20'h0ffff);

    // Random mix: mostly allocations and frees of live addresses, with some
    // frees of arbitrary addresses as noise.
    for (int i = 0; i < 1600; i++) begin
      if (i == 1350) quiet_phase = 1;
      idx = $urandom_range(0, 99);
      if (idx < 55) send_alloc(pick_size());
      else if (idx < 90 && sb.live.size() > 0) begin
        idx = $urandom_range(0, sb.live.size() - 1);
        a = sb.live[idx];
        sb.live.delete(idx);
        send_free(a | 20'($urandom_range(0, 31)));
      end else send_free(20'($urandom));
    end

    // Exhaust the pool to reach the out-of-pages case.
    while (sb.used < NPAGES) send_alloc(13'd4096);
    send_alloc(13'd4096);
    send_alloc(13'd3000);
    in_valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/scsa_pkg.sv
rtl/scsa_ctrl.sv
rtl/scsa_dp.sv
rtl/size_class_slab_allocator_core.sv
rtl/scsa_checker.sv
dv/tb.sv
